[sv/tua_pkg.sv]
// Shared definitions for the tag UID access table: field widths, command and
// status codes, the fixed slot-0 UID, the auth key ROM and the controller handshake.
// Depends on nothing; every other file of the block imports it.
package tua_pkg;

    // Field widths.
    localparam int CMD_W    = 2;
    localparam int UID_W    = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 5;
    localparam int KEY64_W  = 64;
    localparam int CARD_W   = 48;

    // Stream word widths, padded up to whole bytes.
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 184;

    // Default table depth.
    localparam int ENTRIES_DEF = 32;

    // Command codes. The unused code is served as a lookup.
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_PRESENT = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_ABSENT  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_ZERO    = 3'd4;

    // Fixed UID held in slot 0 and the card key returned on a hit.
    localparam logic [UID_W-1:0]  FIXED_UID = 32'h4575_652A;
    localparam logic [CARD_W-1:0] CARD_KEY  = 48'hFFFF_FFFF_FFFF;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;     // take a new word from the input channel
        logic issue;    // read the slot at the scan address and advance
        logic commit;   // apply the result to the table and the output register
    } tua_ctl_t;

    // Datapath to controller status.
    typedef struct packed {
        logic uid_zero;   // the held UID is zero
        logic addr_last;  // the scan address is at the last slot
        logic out_free;   // the output register can take a result
    } tua_sts_t;

    // Auth key ROM: the master key for slot 0, otherwise one of four rows
    // chosen by the low two bits of the slot index. Upper half first.
    function automatic logic [2*KEY64_W-1:0] auth_key(input logic       is_master,
                                                      input logic [1:0] row);
        logic [2*KEY64_W-1:0] key;
        if (is_master) begin
            key = {64'h4254_6963_696E_6F43, 64'h4100_0000_0000_0000};
        end else begin
            case (row)
                2'd0:    key = {64'h3E83_7AEE_9314_DF0B, 64'h120E_D412_56CF_9A51};
                2'd1:    key = {64'h4358_694D_E697_21BB, 64'hD278_83F4_98C3_FAC9};
                2'd2:    key = {64'hD9CE_183A_94F3_25E5, 64'hECFD_2A70_C5E8_5D9F};
                default: key = {64'hD304_EC5A_DEC4_B736, 64'h0DA9_C369_9753_5814};
            endcase
        end
        return key;
    endfunction

endpackage

[sv/tua_ctrl.sv]
// Sequencer for the tag UID access table: accepts a command word, runs the
// slot scan and commits the result. Depends on tua_pkg.
module tua_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  tua_pkg::tua_sts_t sts,
    output tua_pkg::tua_ctl_t ctl
);
    import tua_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_LAST   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Commands follow directly from the state, the status and the input valid.
    assign s_tready   = (state_reg == S_IDLE);
    assign ctl.load   = s_tvalid && s_tready;
    assign ctl.issue  = (state_reg == S_SCAN) && !sts.uid_zero;
    assign ctl.commit = (state_reg == S_FINISH) && sts.out_free;

    // Next state. A zero UID skips the scan.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (ctl.load) state_next = S_SCAN;
            end
            S_SCAN: begin
                if (sts.uid_zero)       state_next = S_FINISH;
                else if (sts.addr_last) state_next = S_LAST;
            end
            S_LAST: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (sts.out_free) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    // The drain state only follows a read of the last slot.
    a_last_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LAST) |-> $past(ctl.issue && sts.addr_last))
        else $error("scan drain entered without reaching the last slot");

    // After a commit the block is ready for the next word.
    a_ready_after_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.commit |=> s_tready)
        else $error("not ready after committing a result");

    // A blocked result holds the controller in the finish state.
    a_hold_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_FINISH) && !sts.out_free) |=> (state_reg == S_FINISH))
        else $error("finish state left while the output register was full");
`endif

endmodule

[sv/tua_dpath.sv]
// Datapath of the tag UID access table: UID memory with per-slot valid bits,
// scan address, match trackers, result decode and output register.
// Depends on tua_pkg.
module tua_dpath #(
    parameter int ENTRIES = tua_pkg::ENTRIES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tua_pkg::tua_ctl_t             ctl,
    output tua_pkg::tua_sts_t             sts,
    input  logic [tua_pkg::CMD_W-1:0]     in_cmd,
    input  logic [tua_pkg::UID_W-1:0]     in_tag_id,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tua_pkg::M_DATA_W-1:0]  m_tdata
);
    import tua_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    // Table storage. Slots never written read as their reset value.
    logic [UID_W-1:0]   mem [ENTRIES];
    logic [ENTRIES-1:0] vld_reg;

    // Held command word.
    logic [CMD_W-1:0] cmd_reg;
    logic [UID_W-1:0] uid_reg;
    logic             zero_reg;

    // Scan address and read stage.
    logic [IDX_W-1:0] addr_reg;
    logic             rd_en_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [UID_W-1:0] rd_data_reg;
    logic             rd_vld_reg;
    logic [UID_W-1:0] rd_word;

    // Match trackers: first hit anywhere, first hit above slot 0, first free slot.
    logic             hit_all_reg;
    logic [IDX_W-1:0] hit_all_idx_reg;
    logic             hit_up_reg;
    logic [IDX_W-1:0] hit_up_idx_reg;
    logic             free_reg;
    logic [IDX_W-1:0] free_idx_reg;

    // Result decode.
    logic [STATUS_W-1:0]  res_status;
    logic [IDX_W-1:0]     res_idx;
    logic                 res_wr;
    logic [UID_W-1:0]     res_wdata;
    logic                 res_keys;
    logic [2*KEY64_W-1:0] key_word;
    logic                 wr_en;

    // Output register.
    logic                 m_valid_reg;
    logic [STATUS_W-1:0]  o_status_reg;
    logic [SLOT_W-1:0]    o_slot_reg;
    logic [KEY64_W-1:0]   o_key_hi_reg;
    logic [KEY64_W-1:0]   o_key_lo_reg;
    logic [CARD_W-1:0]    o_card_reg;

    // Latch the incoming command word.
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            cmd_reg  <= in_cmd;
            uid_reg  <= in_tag_id;
            zero_reg <= (in_tag_id == '0);
        end
    end

    // Scan address counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg <= '0;
        end else if (ctl.load) begin
            addr_reg <= '0;
        end else if (ctl.issue) begin
            addr_reg <= addr_reg + IDX_W'(1);
        end
    end

    assign sts.addr_last = (addr_reg == IDX_W'(ENTRIES - 1));
    assign sts.uid_zero  = zero_reg;
    assign sts.out_free  = !m_valid_reg || m_tready;

    // Memory port: registered read during the scan, write on commit.
    always_ff @(posedge aclk) begin
        if (ctl.issue) begin
            rd_data_reg <= mem[addr_reg];
        end
        if (wr_en) begin
            mem[res_idx] <= res_wdata;
        end
    end

    // Read stage control and the valid bit of the slot read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_en_reg <= 1'b0;
        end else begin
            rd_en_reg <= ctl.issue;
        end
        if (ctl.issue) begin
            rd_idx_reg <= addr_reg;
            rd_vld_reg <= vld_reg[addr_reg];
        end
    end

    // Valid bits: set by the first write to a slot, cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[res_idx] <= 1'b1;
        end
    end

    // An unwritten slot holds the fixed UID at slot 0 and zero elsewhere.
    assign rd_word = rd_vld_reg ? rd_data_reg
                   : ((rd_idx_reg == '0) ? FIXED_UID : '0);

    // Trackers keep the first qualifying slot of the scan.
    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.load) begin
            hit_all_reg <= 1'b0;
            hit_up_reg  <= 1'b0;
            free_reg    <= 1'b0;
        end else if (rd_en_reg) begin
            if (rd_word == uid_reg && !hit_all_reg) begin
                hit_all_reg     <= 1'b1;
                hit_all_idx_reg <= rd_idx_reg;
            end
            if (rd_word == uid_reg && rd_idx_reg != '0 && !hit_up_reg) begin
                hit_up_reg     <= 1'b1;
                hit_up_idx_reg <= rd_idx_reg;
            end
            if (rd_word == '0 && rd_idx_reg != '0 && !free_reg) begin
                free_reg     <= 1'b1;
                free_idx_reg <= rd_idx_reg;
            end
        end
    end

    // Result decode from the finished scan.
    always_comb begin
        res_status = STAT_OK;
        res_idx    = '0;
        res_wr     = 1'b0;
        res_wdata  = '0;
        res_keys   = 1'b0;
        if (zero_reg) begin
            res_status = STAT_ZERO;
        end else begin
            case (cmd_reg)
                CMD_INSERT: begin
                    if (hit_all_reg) begin
                        res_status = STAT_PRESENT;
                    end else if (free_reg) begin
                        res_idx   = free_idx_reg;
                        res_wr    = 1'b1;
                        res_wdata = uid_reg;
                    end else begin
                        res_status = STAT_FULL;
                    end
                end
                CMD_DELETE: begin
                    if (hit_up_reg) begin
                        res_idx = hit_up_idx_reg;
                        res_wr  = 1'b1;
                    end else begin
                        res_status = STAT_ABSENT;
                    end
                end
                default: begin
                    if (hit_all_reg) begin
                        res_idx  = hit_all_idx_reg;
                        res_keys = 1'b1;
                    end else begin
                        res_status = STAT_ABSENT;
                    end
                end
            endcase
        end
    end

    assign wr_en    = ctl.commit && res_wr;
    assign key_word = auth_key(res_idx == '0, 2'(res_idx));

    // Output register: loaded on commit, emptied when the word is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (ctl.commit) begin
            o_status_reg <= res_status;
            o_slot_reg   <= SLOT_W'(res_idx);
            o_key_hi_reg <= res_keys ? key_word[2*KEY64_W-1:KEY64_W] : '0;
            o_key_lo_reg <= res_keys ? key_word[KEY64_W-1:0] : '0;
            o_card_reg   <= res_keys ? CARD_KEY : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {o_card_reg, o_key_lo_reg, o_key_hi_reg, o_slot_reg, o_status_reg};

`ifndef NO_ASSERTIONS
    // The master slot is never written.
    a_master_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (res_idx != '0))
        else $error("write to the master slot");

    // A hit above slot 0 is always also a hit over all slots.
    a_hit_order: assert property (@(posedge aclk) disable iff (!aresetn)
        hit_up_reg |-> hit_all_reg)
        else $error("upper hit recorded without a full-table hit");

    // A failed command reports slot zero.
    a_slot_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.commit && res_status != STAT_OK) |=> (o_slot_reg == '0))
        else $error("nonzero slot reported with a failure status");
`endif

endmodule

[sv/tag_uid_access_table_core.sv]
// Top level of the tag UID access table: stream ports, controller and datapath.
// Depends on tua_pkg, tua_ctrl and tua_dpath.
//
// Usage: each input word carries a command (insert, delete or lookup) and a
// 32-bit tag UID; each word yields exactly one result word with a status,
// the slot index and, on a successful lookup, the slot auth key and card key.
// The block works on one word at a time. After a word is accepted the
// controller reads every slot of the table, one memory read per cycle, then
// commits the result to the output register; a zero UID skips the scan. The
// next word is accepted in the cycle after the commit; no new word is taken
// while a scan runs.
// Reset clears the per-slot valid bits, so slot 0 reads as the fixed UID and
// all other slots as free; no clearing pass is needed. The result sits in an
// output register; while the receiver stalls, the next word may be accepted
// and scanned, and its result waits until the register is free.
module tag_uid_access_table_core #(
    parameter int ENTRIES = tua_pkg::ENTRIES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: cmd [1:0], tag_id [33:2], zero padding [39:34]
    input  logic [tua_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: status [2:0], slot [7:3], auth_key_high [71:8],
    // auth_key_low [135:72], card_key [183:136]
    output logic [tua_pkg::M_DATA_W-1:0]  m_tdata
);
    import tua_pkg::*;

    tua_ctl_t ctl;
    tua_sts_t sts;

    // Sequencer.
    tua_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // Table, scan and output register.
    tua_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .sts       (sts),
        .in_cmd    (s_tdata[CMD_W-1:0]),
        .in_tag_id (s_tdata[CMD_W+UID_W-1:CMD_W]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
